>>> rtl/mau_pkg.sv
// Shared types, constants and helper functions of the modular arithmetic unit.
package mau_pkg;

   localparam logic [29:0] MODULUS    = 30'd1000000007;
   localparam logic [31:0] MODULUS_X2 = 32'd2000000014;
   // floor(2^60 / MODULUS), the Barrett reciprocal
   localparam logic [30:0] BARRETT_MU = 31'd1152921496;
   // 2^30 mod MODULUS, weight of one 30-bit slice of the reduce magnitude
   localparam logic [29:0] RADIX_30   = 30'd73741817;
   // Fermat exponent MODULUS - 2
   localparam logic [62:0] INV_EXP    = 63'd1000000005;
   // reduce folds two 30-bit slices below the top four magnitude bits
   localparam logic [5:0]  RED_LAST   = 6'd1;
   localparam logic [5:0]  EXP_LAST   = 6'd62;

   typedef enum logic [3:0] {
      KIND_REDUCE = 4'd0,
      KIND_ADD    = 4'd1,
      KIND_SUB    = 4'd2,
      KIND_NEG    = 4'd3,
      KIND_MUL    = 4'd4,
      KIND_POW    = 4'd5,
      KIND_INV    = 4'd6,
      KIND_DIV    = 4'd7,
      KIND_EQUAL  = 4'd8
   } kind_type;

   typedef enum logic [1:0] {
      SEL_A_B,
      SEL_ACC_ACC,
      SEL_ACC_BASE,
      SEL_ACC_A
   } mul_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_GO,
      ST_RED_WAIT,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_SQ_GO,
      ST_SQ_WAIT,
      ST_MB_GO,
      ST_MB_WAIT,
      ST_FIN_GO,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        load;
      logic        red_step;
      logic        mul_go;
      mul_sel_type mul_sel;
      logic        exp_shift;
      logic        finish;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic exp_msb;
   } status_type;

   // one conditional subtract is enough: 2^30 < 2 * MODULUS
   function automatic logic [29:0] fold(input logic [29:0] v);
      fold = (v >= MODULUS) ? v - MODULUS : v;
   endfunction

   function automatic logic [29:0] add_mod(input logic [29:0] x, input logic [29:0] y);
      logic [30:0] s;
      s = {1'b0, x} + {1'b0, y};
      add_mod = (s >= {1'b0, MODULUS}) ? 30'(s - {1'b0, MODULUS}) : s[29:0];
   endfunction

   function automatic logic [29:0] neg_mod(input logic [29:0] x);
      neg_mod = (x == 30'd0) ? 30'd0 : MODULUS - x;
   endfunction

endpackage

>>> rtl/mau_mulmod.sv
// Four-stage pipelined modular multiplier with Barrett reduction.
module mau_mulmod (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [29:0] op_a,
   input  logic [29:0] op_b,
   output logic        done,
   output logic [29:0] product
);

   logic [3:0]  valid_ff, valid_in;
   logic [59:0] prod_ff;
   logic [61:0] quot_ff;
   logic [31:0] low2_ff, low3_ff;
   logic [31:0] qp_ff;
   logic [29:0] res_ff;
   logic [31:0] rem;

   assign valid_in = {valid_ff[2:0], go};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // remainder is below 3 * MODULUS, so only the low 32 bits matter
   assign rem = low3_ff - qp_ff;

   always_ff @(posedge clock) begin
      prod_ff <= 60'(op_a) * 60'(op_b);
      quot_ff <= 62'(prod_ff[59:29]) * 62'(mau_pkg::BARRETT_MU);
      low2_ff <= prod_ff[31:0];
      qp_ff   <= 32'(quot_ff[61:31]) * 32'(mau_pkg::MODULUS);
      low3_ff <= low2_ff;
      if (rem >= mau_pkg::MODULUS_X2) begin
         res_ff <= 30'(rem - mau_pkg::MODULUS_X2);
      end else if (rem >= 32'(mau_pkg::MODULUS)) begin
         res_ff <= 30'(rem - 32'(mau_pkg::MODULUS));
      end else begin
         res_ff <= rem[29:0];
      end
   end

   assign done    = valid_ff[3];
   assign product = res_ff;

endmodule

>>> rtl/mau_datapath.sv
// Operand, exponent and magnitude registers, result select and the shared multiplier.
module mau_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  mau_pkg::cmd_type     cmd,
   output mau_pkg::status_type  status,
   input  logic [3:0]           req_kind,
   input  logic [29:0]          req_operand_a,
   input  logic [29:0]          req_operand_b,
   input  logic signed [63:0]   req_raw_value,
   input  logic [62:0]          req_exponent,
   output logic [29:0]          rsp_result,
   output logic                 rsp_equal_flag
);

   logic [3:0]  kind_ff;
   logic [29:0] a_ff, b_ff, base_ff, acc_ff;
   logic [62:0] exp_ff;
   logic [63:0] mag_ff;
   logic        neg_ff;
   logic [29:0] result_ff;
   logic        flag_ff;

   logic [29:0] a_fold, b_fold;
   logic [29:0] mul_a, mul_b, mul_p;
   logic        mul_done;
   logic [63:0] mag_in;
   logic [29:0] slice_fold;
   logic [29:0] result_in;
   logic        flag_in;

   assign a_fold = mau_pkg::fold(req_operand_a);
   assign b_fold = mau_pkg::fold(req_operand_b);

   always_comb begin
      case (cmd.mul_sel)
         mau_pkg::SEL_A_B: begin
            mul_a = a_ff;
            mul_b = b_ff;
         end
         mau_pkg::SEL_ACC_ACC: begin
            mul_a = acc_ff;
            mul_b = acc_ff;
         end
         mau_pkg::SEL_ACC_BASE: begin
            mul_a = acc_ff;
            mul_b = base_ff;
         end
         mau_pkg::SEL_ACC_A: begin
            mul_a = acc_ff;
            mul_b = a_ff;
         end
         default: begin
            mul_a = a_ff;
            mul_b = b_ff;
         end
      endcase
   end

   mau_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .go      (cmd.mul_go),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   // reduce: acc = acc * 2^30 + next slice (mod p), seeded with the top four bits
   assign mag_in     = req_raw_value[63] ? 64'(-req_raw_value) : 64'(req_raw_value);
   assign slice_fold = mau_pkg::fold(mag_ff[59:30]);

   always_comb begin
      result_in = 30'd0;
      flag_in   = 1'b0;
      case (kind_ff)
         mau_pkg::KIND_REDUCE: result_in = neg_ff ? mau_pkg::neg_mod(acc_ff) : acc_ff;
         mau_pkg::KIND_ADD:    result_in = mau_pkg::add_mod(a_ff, b_ff);
         mau_pkg::KIND_SUB:    result_in = mau_pkg::add_mod(a_ff, mau_pkg::neg_mod(b_ff));
         mau_pkg::KIND_NEG:    result_in = mau_pkg::neg_mod(a_ff);
         mau_pkg::KIND_MUL,
         mau_pkg::KIND_POW,
         mau_pkg::KIND_INV,
         mau_pkg::KIND_DIV:    result_in = acc_ff;
         mau_pkg::KIND_EQUAL:  flag_in = (a_ff == b_ff);
         default: begin
            result_in = 30'd0;
            flag_in   = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         a_ff    <= a_fold;
         b_ff    <= b_fold;
         base_ff <= (req_kind == mau_pkg::KIND_DIV) ? b_fold :
                    (req_kind == mau_pkg::KIND_REDUCE) ? mau_pkg::RADIX_30 : a_fold;
         exp_ff  <= (req_kind == mau_pkg::KIND_POW) ? req_exponent : mau_pkg::INV_EXP;
         acc_ff  <= (req_kind == mau_pkg::KIND_REDUCE) ? 30'(mag_in[63:60]) : 30'd1;
         neg_ff  <= req_raw_value[63];
         mag_ff  <= mag_in;
      end else begin
         if (mul_done) begin
            if (cmd.red_step) begin
               acc_ff <= mau_pkg::add_mod(mul_p, slice_fold);
               mag_ff <= {mag_ff[33:0], 30'd0};
            end else begin
               acc_ff <= mul_p;
            end
         end
         if (cmd.exp_shift) begin
            exp_ff <= {exp_ff[61:0], 1'b0};
         end
      end
      if (cmd.finish) begin
         result_ff <= result_in;
         flag_ff   <= flag_in;
      end
   end

   assign status.mul_done = mul_done;
   assign status.exp_msb  = exp_ff[62];
   assign rsp_result      = result_ff;
   assign rsp_equal_flag  = flag_ff;

endmodule

>>> rtl/mau_ctrl.sv
// Sequencer: decodes the operation and steps the reduce and square-and-multiply loops.
module mau_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [3:0]           req_kind,
   input  mau_pkg::status_type  status,
   output mau_pkg::cmd_type     cmd,
   output logic                 busy,
   output logic                 rsp_strobe
);

   mau_pkg::state_type state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [3:0] kind_ff, kind_in;
   logic       strobe_ff, strobe_in;
   logic       last_bit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mau_pkg::ST_IDLE;
         strobe_ff <= 1'b0;
         cnt_ff    <= 6'd0;
         kind_ff   <= 4'd0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         cnt_ff    <= cnt_in;
         kind_ff   <= kind_in;
      end
   end

   assign last_bit = (cnt_ff == mau_pkg::EXP_LAST);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      kind_in   = kind_ff;
      strobe_in = 1'b0;
      cmd       = '0;
      cmd.mul_sel = mau_pkg::SEL_A_B;
      case (state_ff)
         mau_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               kind_in  = req_kind;
               cnt_in   = 6'd0;
               case (req_kind)
                  mau_pkg::KIND_REDUCE: state_in = mau_pkg::ST_RED_GO;
                  mau_pkg::KIND_MUL:    state_in = mau_pkg::ST_MUL_GO;
                  mau_pkg::KIND_POW,
                  mau_pkg::KIND_INV,
                  mau_pkg::KIND_DIV:    state_in = mau_pkg::ST_SQ_GO;
                  default:              state_in = mau_pkg::ST_FINISH;
               endcase
            end
         end
         mau_pkg::ST_RED_GO: begin
            // acc times 2^30 mod p, next slice added on capture
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = mau_pkg::SEL_ACC_BASE;
            state_in    = mau_pkg::ST_RED_WAIT;
         end
         mau_pkg::ST_RED_WAIT: begin
            if (status.mul_done) begin
               cmd.red_step = 1'b1;
               if (cnt_ff == mau_pkg::RED_LAST) begin
                  state_in = mau_pkg::ST_FINISH;
               end else begin
                  cnt_in   = cnt_ff + 6'd1;
                  state_in = mau_pkg::ST_RED_GO;
               end
            end
         end
         mau_pkg::ST_MUL_GO: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = mau_pkg::SEL_A_B;
            state_in    = mau_pkg::ST_MUL_WAIT;
         end
         mau_pkg::ST_MUL_WAIT: begin
            if (status.mul_done) begin
               state_in = mau_pkg::ST_FINISH;
            end
         end
         mau_pkg::ST_SQ_GO: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = mau_pkg::SEL_ACC_ACC;
            state_in    = mau_pkg::ST_SQ_WAIT;
         end
         mau_pkg::ST_SQ_WAIT: begin
            if (status.mul_done) begin
               if (status.exp_msb) begin
                  state_in = mau_pkg::ST_MB_GO;
               end else begin
                  cmd.exp_shift = 1'b1;
                  if (last_bit) begin
                     state_in = (kind_ff == mau_pkg::KIND_DIV) ?
                                mau_pkg::ST_FIN_GO : mau_pkg::ST_FINISH;
                  end else begin
                     cnt_in   = cnt_ff + 6'd1;
                     state_in = mau_pkg::ST_SQ_GO;
                  end
               end
            end
         end
         mau_pkg::ST_MB_GO: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = mau_pkg::SEL_ACC_BASE;
            state_in    = mau_pkg::ST_MB_WAIT;
         end
         mau_pkg::ST_MB_WAIT: begin
            if (status.mul_done) begin
               cmd.exp_shift = 1'b1;
               if (last_bit) begin
                  state_in = (kind_ff == mau_pkg::KIND_DIV) ?
                             mau_pkg::ST_FIN_GO : mau_pkg::ST_FINISH;
               end else begin
                  cnt_in   = cnt_ff + 6'd1;
                  state_in = mau_pkg::ST_SQ_GO;
               end
            end
         end
         mau_pkg::ST_FIN_GO: begin
            // divide: inverse of b times a
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = mau_pkg::SEL_ACC_A;
            state_in    = mau_pkg::ST_MUL_WAIT;
         end
         mau_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            strobe_in  = 1'b1;
            state_in   = mau_pkg::ST_IDLE;
         end
         default: state_in = mau_pkg::ST_IDLE;
      endcase
   end

   assign busy       = (state_ff != mau_pkg::ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

>>> rtl/modular_arithmetic_unit.sv
// Top level of the modular arithmetic unit (prime modulus 1000000007).
//
// Use:
//   Command channel: drive req_* and raise start; the word is taken at a
//   rising edge where start is high and busy is low. busy stays high until
//   the result is posted. One word is worked at a time.
//   Result channel: rsp_result / rsp_equal_flag are valid for exactly one
//   cycle while rsp_strobe is high. The receiver cannot stall; it must take
//   the word in that cycle. busy drops in the same cycle the strobe shows,
//   so a new command may be issued while the result is on the port.
//   Operands above the modulus are folded once on entry.
// Sequence from accept to strobe, per operation:
//   add, sub, neg, equal, unused codes: straight to the finish step
//   reduce: two multiply-add folds of 30-bit magnitude slices
//   mul: one multiply
//   pow, inverse: one squaring per exponent bit, one multiply per one bit
//   div: inverse of b, then one multiply by a
//   Every multiply goes through one shared 4-stage Barrett multiplier;
//   the 63 squarings of the exponent walk dominate the run time.
// Reset: synchronous, active high; returns the sequencer to idle with no
//   strobe pending. Result registers are not cleared.
module modular_arithmetic_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_kind,
   input  logic [29:0]        req_operand_a,
   input  logic [29:0]        req_operand_b,
   input  logic signed [63:0] req_raw_value,
   input  logic [62:0]        req_exponent,
   output logic               rsp_strobe,
   output logic [29:0]        rsp_result,
   output logic               rsp_equal_flag
);

   mau_pkg::cmd_type    cmd;
   mau_pkg::status_type status;

   // sequencer: owns the state, step counter and strobe
   mau_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_kind   (req_kind),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // datapath: operands, exponent shifter, magnitude, multiplier, result regs
   mau_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_kind       (req_kind),
      .req_operand_a  (req_operand_a),
      .req_operand_b  (req_operand_b),
      .req_raw_value  (req_raw_value),
      .req_exponent   (req_exponent),
      .rsp_result     (rsp_result),
      .rsp_equal_flag (rsp_equal_flag)
   );

endmodule

>>> rtl/mau_checker.sv
// Port-level checker for the modular arithmetic unit, bound to the top level.
module mau_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic [29:0]        rsp_result,
   input logic               rsp_equal_flag
);

   // an accepted command keeps the unit busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // a result only ends a busy period
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("strobe without a command in flight");

   // the end of a busy period posts exactly one result
   a_fell_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a result");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   // compare results carry a zero residue
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_equal_flag) |-> (rsp_result == 30'd0))
      else $error("equal flag with nonzero result");

endmodule

bind modular_arithmetic_unit mau_checker u_checker (.*);

>>> bench/tb_modular_arithmetic_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench of the modular arithmetic unit: directed and random command words.
module tb_modular_arithmetic_unit;

   // Prime modulus at 64 bits so that products of two residues stay exact.
   localparam bit [63:0]   PRIME     = 64'(mau_pkg::MODULUS);
   localparam logic [29:0] MOD30     = mau_pkg::MODULUS;
   localparam logic [29:0] TOP_RES   = mau_pkg::MODULUS - 30'd1;
   localparam int          CLOCK_LIM = 3000000;
   // Settle time after the last result; covers the slowest command (power with an all-ones exponent).
   localparam int          DRAIN_CYC = 700;
   localparam int          PHASE_LEN = 300;

   // One command word as the sender presents it.
   typedef struct {
      logic [3:0]  kind;
      logic [29:0] operand_a;
      logic [29:0] operand_b;
      logic [63:0] raw_value;
      logic [62:0] exponent;
   } cmd_word_type;

   // One result word as the unit posts it.
   typedef struct {
      logic [29:0] result;
      logic        equal_flag;
   } residue_word_type;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               start          = 1'b0;
   logic               busy;
   logic [3:0]         req_kind       = '0;
   logic [29:0]        req_operand_a  = '0;
   logic [29:0]        req_operand_b  = '0;
   logic signed [63:0] req_raw_value  = '0;
   logic [62:0]        req_exponent   = '0;
   logic               rsp_strobe;
   logic [29:0]        rsp_result;
   logic               rsp_equal_flag;

   cmd_word_type     cmd_pending[$];   // words not yet offered to the unit
   residue_word_type residue_due[$];   // predicted results, oldest first
   cmd_word_type     cmd_offered;      // word currently on the req_ ports
   bit               offer_loaded   = 1'b0;
   int               words_total    = 0;
   int               words_sent     = 0;
   int               directed_count = 0;
   int               mismatch_count = 0;
   int               cycle_count    = 0;

   modular_arithmetic_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_operand_a  (req_operand_a),
      .req_operand_b  (req_operand_b),
      .req_raw_value  (req_raw_value),
      .req_exponent   (req_exponent),
      .rsp_strobe     (rsp_strobe),
      .rsp_result     (rsp_result),
      .rsp_equal_flag (rsp_equal_flag)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Operands may sit above the modulus; one subtract brings them back
   // since 2^30 < 2 * modulus.
   function automatic bit [63:0] fold30(input logic [29:0] v);
      bit [63:0] w;
      w = 64'(v);
      fold30 = (w >= PRIME) ? w - PRIME : w;
   endfunction

   // Square-and-multiply over all 63 exponent bits, MSB first.
   function automatic bit [63:0] pow_mod(input bit [63:0] base, input bit [62:0] e);
      bit [63:0] acc;
      int        i;
      acc = 64'd1;
      for (i = 62; i >= 0; i--) begin
         acc = (acc * acc) % PRIME;
         if (e[i])
            acc = (acc * base) % PRIME;
      end
      pow_mod = acc;
   endfunction

   function automatic residue_word_type predict_residue(input cmd_word_type c);
      residue_word_type r;
      bit [63:0]        a;
      bit [63:0]        b;
      bit [63:0]        mag;
      bit [63:0]        rem;
      bit [63:0]        nb;
      a            = fold30(c.operand_a);
      b            = fold30(c.operand_b);
      r.result     = '0;
      r.equal_flag = 1'b0;
      case (c.kind)
         mau_pkg::KIND_REDUCE: begin
            // negative values: reduce the magnitude, then mirror;
            // the most negative value has magnitude 2^63, still exact
            if (c.raw_value[63]) begin
               mag      = ~c.raw_value + 64'd1;
               rem      = mag % PRIME;
               r.result = 30'((rem == 0) ? 64'd0 : PRIME - rem);
            end else begin
               r.result = 30'(c.raw_value % PRIME);
            end
         end
         mau_pkg::KIND_ADD: begin
            r.result = 30'((a + b >= PRIME) ? a + b - PRIME : a + b);
         end
         mau_pkg::KIND_SUB: begin
            nb       = (b == 0) ? 64'd0 : PRIME - b;
            r.result = 30'((a + nb >= PRIME) ? a + nb - PRIME : a + nb);
         end
         mau_pkg::KIND_NEG: r.result = 30'((a == 0) ? 64'd0 : PRIME - a);
         mau_pkg::KIND_MUL: r.result = 30'((a * b) % PRIME);
         mau_pkg::KIND_POW: r.result = 30'(pow_mod(a, c.exponent));
         // Fermat inverse; zero maps to zero with no flag
         mau_pkg::KIND_INV: r.result = 30'(pow_mod(a, 63'(PRIME - 2)));
         mau_pkg::KIND_DIV: r.result = 30'((a * pow_mod(b, 63'(PRIME - 2))) % PRIME);
         mau_pkg::KIND_EQUAL: r.equal_flag = (a == b);
         default: ;  // codes nine to fifteen post an all-zero word
      endcase
      predict_residue = r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic logic [29:0] rand_operand();
      logic [29:0] v;
      case ($urandom_range(0, 9))
         0: v = 30'($urandom);  // full 30 bits, may be unreduced
         1: begin
            case ($urandom_range(0, 4))
               0: v = 30'd0;
               1: v = 30'd1;
               2: v = TOP_RES;
               3: v = MOD30;
               default: v = '1;
            endcase
         end
         default: v = 30'($urandom_range(0, 1000000006));
      endcase
      rand_operand = v;
   endfunction

   function automatic cmd_word_type rand_cmd();
      cmd_word_type c;
      if ($urandom_range(0, 99) < 5)
         c.kind = 4'($urandom_range(9, 15));
      else
         c.kind = 4'($urandom_range(0, 8));
      c.operand_a = rand_operand();
      c.operand_b = rand_operand();
      // compare words need equal pairs often, also unreduced aliases
      if (c.kind == mau_pkg::KIND_EQUAL && $urandom_range(0, 1) == 1) begin
         if (c.operand_a < (30'h3FFFFFFF - MOD30) && $urandom_range(0, 1) == 1)
            c.operand_b = c.operand_a + MOD30;
         else
            c.operand_b = c.operand_a;
      end
      case ($urandom_range(0, 7))
         0: c.raw_value = 64'($signed(32'($urandom_range(0, 2000)) - 32'd1000));
         1: c.raw_value = {1'b1, 63'd0};
         2: c.raw_value = {1'b0, {63{1'b1}}};
         default: c.raw_value = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 5))
         0: c.exponent = 63'($urandom_range(0, 20));
         1: c.exponent = 63'd0;
         default: c.exponent = 63'({$urandom, $urandom});
      endcase
      rand_cmd = c;
   endfunction

   function automatic cmd_word_type mk_cmd(input logic [3:0] k, input logic [29:0] a,
                                           input logic [29:0] b, input logic [63:0] raw,
                                           input logic [62:0] e);
      cmd_word_type c;
      c.kind      = k;
      c.operand_a = a;
      c.operand_b = b;
      c.raw_value = raw;
      c.exponent  = e;
      mk_cmd = c;
   endfunction

   // ------------------------------------------------------------------
   // Driver: offers the head of cmd_pending; a word is taken on an edge
   // with start high and busy low. Start is written once per edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : drive_proc
      bit go;
      int idle_pct;
      bit hold;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            residue_due.push_back(predict_residue(cmd_offered));
            words_sent++;
            offer_loaded = 1'b0;
         end
         if (!offer_loaded && cmd_pending.size() > 0) begin
            cmd_offered   = cmd_pending.pop_front();
            offer_loaded  = 1'b1;
            req_kind      <= cmd_offered.kind;
            req_operand_a <= cmd_offered.operand_a;
            req_operand_b <= cmd_offered.operand_b;
            req_raw_value <= cmd_offered.raw_value;
            req_exponent  <= cmd_offered.exponent;
         end
         // idle mix: light, then heavy, then none
         if (words_sent < PHASE_LEN)
            idle_pct = 21;
         else if (words_sent < 2 * PHASE_LEN)
            idle_pct = 71;
         else
            idle_pct = 0;
         // at phase boundaries the sender drains the unit before going on
         hold = (words_sent == directed_count || words_sent == PHASE_LEN ||
                 words_sent == 2 * PHASE_LEN) && residue_due.size() > 0;
         go = offer_loaded && !hold && ($urandom_range(0, 99) >= idle_pct);
         start <= go;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: each strobed word is checked against the oldest prediction.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_proc
      residue_word_type want;
      if (!reset && rsp_strobe) begin
         if (residue_due.size() == 0) begin
            $display("%0t: unexpected result word: expected none, actual result %0d flag %0b",
                     $time, rsp_result, rsp_equal_flag);
            mismatch_count++;
         end else begin
            want = residue_due.pop_front();
            if (rsp_result !== want.result) begin
               $display("%0t: result mismatch: expected %0d, actual %0d",
                        $time, want.result, rsp_result);
               mismatch_count++;
            end
            if (rsp_equal_flag !== want.equal_flag) begin
               $display("%0t: equal_flag mismatch: expected %0b, actual %0b",
                        $time, want.equal_flag, rsp_equal_flag);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CLOCK_LIM) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : stim_proc
      int n;
      // --- directed words: field extremes, every operation, corner cases ---
      // reduce: zero, max positive, most negative, -1, -modulus
      cmd_pending.push_back(mk_cmd(mau_pkg::KIND_REDUCE, 30'd0, 30'd0, 64'd0, 63'd0));
      cmd_pending.push_back(mk_cmd(mau_pkg::KIND_REDUCE, 30'd0, 30'd0, {1'b0, {63{1'b1}}},
                                   63'd0));
      cmd_pending.push_back(mk_cmd(mau_pkg::KIND_REDUCE, 30'd0, 30'd0, {1'b1, 63'd0}, 63'd0));
      cmd_pending.push_back(mk_cmd(mau_pkg::KIND_REDUCE, 30'd0, 30'd0, '1, 63'd0));
      cmd_pending.push_back(mk_cmd(mau_pkg::KIND_REDUCE, 30'd0, 30'd0, -64'sd1000000007,
                                   63'd0));
      // add with wrap, and with unreduced operands
      cmd_pending.push_back(mk_cmd(mau_pkg::KIND_ADD, TOP_RES, TOP_RES, '0, '0));
      cmd_pending.push_back(mk_cmd(mau_pkg::KIND_ADD, '1, 30'd1, '0, '0));
      // sub borrow, neg of zero and of max residue
      cmd_pending.push_back(mk_cmd(mau_pkg::KIND_SUB, 30'd0, 30'd1, '0, '0));
      cmd_pending.push_back(mk_cmd(mau_pkg::KIND_NEG, 30'd0, 30'd0, '0, '0));
      cmd_pending.push_back(mk_cmd(mau_pkg::KIND_NEG, TOP_RES, 30'd0, '0, '0));
      // mul at the top of the range, reduced and unreduced
      cmd_pending.push_back(mk_cmd(mau_pkg::KIND_MUL, TOP_RES, TOP_RES, '0, '0));
      cmd_pending.push_back(mk_cmd(mau_pkg::KIND_MUL, '1, '1, '0, '0));
      // pow: zero to the zero is one, max exponent, zero base
      cmd_pending.push_back(mk_cmd(mau_pkg::KIND_POW, 30'd0, 30'd0, '0, 63'd0));
      cmd_pending.push_back(mk_cmd(mau_pkg::KIND_POW, 30'd2, 30'd0, '0, '1));
      cmd_pending.push_back(mk_cmd(mau_pkg::KIND_POW, 30'd0, 30'd0, '0, 63'd5));
      // inverse of zero gives zero; ordinary and max residue
      cmd_pending.push_back(mk_cmd(mau_pkg::KIND_INV, 30'd0, 30'd0, '0, '0));
      cmd_pending.push_back(mk_cmd(mau_pkg::KIND_INV, 30'd2, 30'd0, '0, '0));
      cmd_pending.push_back(mk_cmd(mau_pkg::KIND_INV, TOP_RES, 30'd0, '0, '0));
      // divide by zero gives zero; exact divide
      cmd_pending.push_back(mk_cmd(mau_pkg::KIND_DIV, 30'd12345, 30'd0, '0, '0));
      cmd_pending.push_back(mk_cmd(mau_pkg::KIND_DIV, 30'd6, 30'd3, '0, '0));
      // compare: equal, equal after folding, unequal
      cmd_pending.push_back(mk_cmd(mau_pkg::KIND_EQUAL, 30'd77, 30'd77, '0, '0));
      cmd_pending.push_back(mk_cmd(mau_pkg::KIND_EQUAL, 30'd5, 30'd5 + MOD30, '0, '0));
      cmd_pending.push_back(mk_cmd(mau_pkg::KIND_EQUAL, 30'd0, 30'd1, '0, '0));
      // unused codes
      cmd_pending.push_back(mk_cmd(4'd9, 30'd3, 30'd3, '1, '1));
      cmd_pending.push_back(mk_cmd(4'hF, '1, '1, '1, '1));
      directed_count = cmd_pending.size();

      // --- random words ---
      for (n = 0; n < 900; n++)
         cmd_pending.push_back(rand_cmd());
      words_total = cmd_pending.size();

      // --- reset, then release ---
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // --- drain: all words taken, all results in, then settle ---
      while (words_sent < words_total || residue_due.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);

      if (mismatch_count == 0 && residue_due.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
